### design/bpbtb_pkg.sv
package bpbtb_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BTB_INDEX_BITS = 3'd0,
        CFG_HISTORY_BITS   = 3'd1,
        CFG_TAG_BITS       = 3'd2,
        CFG_INIT_COUNTER   = 3'd3,
        CFG_GLOBAL_HISTORY = 3'd4,
        CFG_GLOBAL_TABLE   = 3'd5,
        CFG_SHARE_MODE     = 3'd6
    } t_cfg_idx;

    // History sharing modes
    typedef enum logic [1:0] {
        SHARE_NONE = 2'd0,
        SHARE_PC2  = 2'd1,
        SHARE_PC16 = 2'd2
    } t_share;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    // Two-bit saturating counter
    localparam int         CTR_W   = 2;
    localparam logic [1:0] CTR_MIN = 2'd0;
    localparam logic [1:0] CTR_MAX = 2'd3;
    localparam logic [1:0] CTR_WT  = 2'd2;

    localparam logic [31:0] PC_STEP       = 32'd4;
    localparam int          PC_LO_SHIFT   = 2;
    localparam int          PC_HI_SHIFT   = 16;

    // Configuration register file
    typedef struct packed {
        logic [2:0] btb_index_bits;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] init_counter;
        logic       global_history;
        logic       global_table;
        logic [1:0] share_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        btb_index_bits: 3'd0,
        history_bits:   4'd1,
        tag_bits:       5'd0,
        init_counter:   2'd1,
        global_history: 1'b0,
        global_table:   1'b0,
        share_mode:     2'd0
    };

endpackage

### design/bpbtb_ram.sv
module bpbtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/two_level_branch_predictor_btb.sv
// Channel  Direction  Handshake          Payload
// -------  ---------  -----------------  ------------------------------------------------
// input    in         i_valid / o_stall  i_opcode, i_pc, i_target_pc, i_taken
// result   out        o_valid / i_stall  o_predicted_taken, o_predicted_target,
//                                        o_branch_count, o_flush_count
// config   in         i_cfg_we           i_cfg_addr, i_cfg_wdata
//
// One word per cycle sustained while the result side is not stalled. Each word
// passes the memory-read stage, where the accept edge reads the BTB and counter-row
// memories, then the result register. A word accepted in the same cycle as an update
// of the same entry or row gets the written data through a bypass register.
// Reset (synchronous, active low) and every config write to a known index clear
// the entry and row valid bits in flops at once; there is no clearing pass.
// A stalled result holds in the output register while one more word waits in
// the memory-read stage; o_stall rises only when both are full.
module two_level_branch_predictor_btb #(
    parameter int BTB_DEPTH = 32,
    parameter int HIST_MAX  = 8,
    parameter int TAG_MAX   = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_target_pc,
    input  logic        i_taken,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_predicted_taken,
    output logic [31:0] o_predicted_target,
    output logic [31:0] o_branch_count,
    output logic [31:0] o_flush_count
);

    localparam int IDX_W   = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
    localparam int IDX_MAX = $clog2(BTB_DEPTH + 1) - 1;
    localparam int ROW_N   = 1 << HIST_MAX;
    localparam int ROW_W   = bpbtb_pkg::CTR_W * ROW_N;
    localparam int BTB_W   = TAG_MAX + 32 + HIST_MAX;

    // Configuration
    bpbtb_pkg::t_cfg r_cfg;
    logic            cfg_clear;

    // Pipeline
    logic             r_s1_valid;
    logic             r_s1_op;
    logic [31:0]      r_s1_pc;
    logic [31:0]      r_s1_tgt;
    logic             r_s1_tk;
    logic [IDX_W-1:0] r_s1_idx;
    logic [IDX_W-1:0] r_s1_row;
    logic             s1_adv;
    logic             in_acc;

    // Per-entry and per-row state
    logic [BTB_DEPTH-1:0] r_entry_valid;
    logic [BTB_DEPTH-1:0] r_row_valid;
    logic [HIST_MAX-1:0]  r_ghist;
    logic [31:0]          r_branches;
    logic [31:0]          r_flushes;

    // Bypass of the write made at the accept edge
    logic             r_fwd_btb;
    logic [BTB_W-1:0] r_fwd_btb_data;
    logic             r_fwd_row;
    logic [ROW_W-1:0] r_fwd_row_data;

    // Output register
    logic        r_out_valid;
    logic        r_out_taken;
    logic [31:0] r_out_target;
    logic [31:0] r_out_branches;
    logic [31:0] r_out_flushes;

    // Address side
    logic [3:0]       eff_idx;
    logic [IDX_W-1:0] idx_mask;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] n_row;

    // Memory read data
    logic [BTB_W-1:0] btb_rdata;
    logic [ROW_W-1:0] row_rdata;

    // Stage 1 logic
    logic [4:0]          eff_tag;
    logic [3:0]          eff_hist;
    logic [HIST_MAX-1:0] hmask;
    logic [TAG_MAX-1:0]  s1_tag;
    logic [BTB_W-1:0]    btb_word;
    logic [TAG_MAX-1:0]  word_tag;
    logic [31:0]         word_target;
    logic [HIST_MAX-1:0] word_hist;
    logic [ROW_W-1:0]    init_row;
    logic [ROW_W-1:0]    row_data;
    logic                s1_hit;
    logic [HIST_MAX-1:0] hist_pred;
    logic [HIST_MAX-1:0] pred_slot;
    logic [1:0]          ctr_pred;
    logic                s1_pred;
    logic [31:0]         pc_next;
    logic [31:0]         s1_next;
    logic                s1_flush;
    logic                s1_alloc;
    logic [HIST_MAX-1:0] hist_upd;
    logic [ROW_W-1:0]    base_row;
    logic [HIST_MAX-1:0] upd_slot;
    logic [1:0]          ctr_old;
    logic [1:0]          ctr_new;
    logic [ROW_W-1:0]    new_row;
    logic [HIST_MAX-1:0] new_hist;
    logic [BTB_W-1:0]    new_btb;
    logic                s1_write;

    // Counter slot: history, optionally XORed with pc bits
    function automatic logic [HIST_MAX-1:0] f_slot(
        input logic [31:0]         pc,
        input logic [HIST_MAX-1:0] hist,
        input logic [HIST_MAX-1:0] mask,
        input logic [1:0]          mode
    );
        logic [HIST_MAX-1:0] h;
        h = hist & mask;
        unique case (bpbtb_pkg::t_share'(mode))
            bpbtb_pkg::SHARE_PC2:  h = (h ^ HIST_MAX'(pc >> bpbtb_pkg::PC_LO_SHIFT)) & mask;
            bpbtb_pkg::SHARE_PC16: h = (h ^ HIST_MAX'(pc >> bpbtb_pkg::PC_HI_SHIFT)) & mask;
            default:               h = hist & mask;
        endcase
        return h;
    endfunction

    // Config write decode: known indexes update and clear the predictor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bpbtb_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (bpbtb_pkg::t_cfg_idx'(i_cfg_addr))
                bpbtb_pkg::CFG_BTB_INDEX_BITS: r_cfg.btb_index_bits <= i_cfg_wdata[2:0];
                bpbtb_pkg::CFG_HISTORY_BITS:   r_cfg.history_bits   <= i_cfg_wdata[3:0];
                bpbtb_pkg::CFG_TAG_BITS:       r_cfg.tag_bits       <= i_cfg_wdata;
                bpbtb_pkg::CFG_INIT_COUNTER:   r_cfg.init_counter   <= i_cfg_wdata[1:0];
                bpbtb_pkg::CFG_GLOBAL_HISTORY: r_cfg.global_history <= i_cfg_wdata[0];
                bpbtb_pkg::CFG_GLOBAL_TABLE:   r_cfg.global_table   <= i_cfg_wdata[0];
                bpbtb_pkg::CFG_SHARE_MODE:     r_cfg.share_mode     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (bpbtb_pkg::t_cfg_idx'(i_cfg_addr))
            bpbtb_pkg::CFG_BTB_INDEX_BITS,
            bpbtb_pkg::CFG_HISTORY_BITS,
            bpbtb_pkg::CFG_TAG_BITS,
            bpbtb_pkg::CFG_INIT_COUNTER,
            bpbtb_pkg::CFG_GLOBAL_HISTORY,
            bpbtb_pkg::CFG_GLOBAL_TABLE,
            bpbtb_pkg::CFG_SHARE_MODE: cfg_clear = i_cfg_we;
            default:                   cfg_clear = 1'b0;
        endcase
    end

    // Handshake
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    // Entry index and counter row from the incoming pc
    always_comb begin
        eff_idx  = ({1'b0, r_cfg.btb_index_bits} > 4'(IDX_MAX)) ?
                   4'(IDX_MAX) : {1'b0, r_cfg.btb_index_bits};
        idx_mask = IDX_W'((32'd1 << eff_idx) - 32'd1);
        n_idx    = i_pc[2 +: IDX_W] & idx_mask;
        n_row    = r_cfg.global_table ? '0 : n_idx;
    end

    // Hold the word in stage 1 while the result side is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= i_opcode;
            r_s1_pc  <= i_pc;
            r_s1_tgt <= i_target_pc;
            r_s1_tk  <= i_taken;
            r_s1_idx <= n_idx;
            r_s1_row <= n_row;
        end
    end

    // Capture the bypass at the accept edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_btb <= 1'b0;
            r_fwd_row <= 1'b0;
        end else if (in_acc) begin
            r_fwd_btb <= s1_write && (r_s1_idx == n_idx);
            r_fwd_row <= s1_write && (r_s1_row == n_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fwd_btb_data <= new_btb;
            r_fwd_row_data <= new_row;
        end
    end

    // BTB entries: tag, target and local history
    bpbtb_ram #(
        .WIDTH (BTB_W),
        .DEPTH (BTB_DEPTH)
    ) u_btb_ram (
        .i_clk   (i_clk),
        .i_we    (s1_write),
        .i_waddr (r_s1_idx),
        .i_wdata (new_btb),
        .i_re    (in_acc),
        .i_raddr (n_idx),
        .o_rdata (btb_rdata)
    );

    // Counter rows, one word per row
    bpbtb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BTB_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (s1_write),
        .i_waddr (r_s1_row),
        .i_wdata (new_row),
        .i_re    (in_acc),
        .i_raddr (n_row),
        .o_rdata (row_rdata)
    );

    // Lookup and update of the word in stage 1
    always_comb begin
        eff_tag  = (r_cfg.tag_bits > 5'(TAG_MAX)) ? 5'(TAG_MAX) : r_cfg.tag_bits;
        eff_hist = (r_cfg.history_bits == 4'd0) ? 4'd1 :
                   ((r_cfg.history_bits > 4'(HIST_MAX)) ? 4'(HIST_MAX) : r_cfg.history_bits);
        hmask    = HIST_MAX'((32'd1 << eff_hist) - 32'd1);
        s1_tag   = TAG_MAX'((r_s1_pc >> (6'd2 + {2'b00, eff_idx})) &
                            ((32'd1 << eff_tag) - 32'd1));

        btb_word    = r_fwd_btb ? r_fwd_btb_data : btb_rdata;
        word_tag    = btb_word[BTB_W-1 -: TAG_MAX];
        word_target = btb_word[HIST_MAX +: 32];
        word_hist   = btb_word[HIST_MAX-1:0];

        init_row = {ROW_N{r_cfg.init_counter}};
        if (r_fwd_row) begin
            row_data = r_fwd_row_data;
        end else if (r_row_valid[r_s1_row]) begin
            row_data = row_rdata;
        end else begin
            row_data = init_row;
        end

        // Predict
        s1_hit    = r_entry_valid[r_s1_idx] && (word_tag == s1_tag);
        hist_pred = r_cfg.global_history ? r_ghist : word_hist;
        pred_slot = f_slot(r_s1_pc, hist_pred, hmask, r_cfg.share_mode);
        ctr_pred  = row_data[{pred_slot, 1'b0} +: bpbtb_pkg::CTR_W];
        s1_pred   = s1_hit && (ctr_pred >= bpbtb_pkg::CTR_WT);
        pc_next   = r_s1_pc + bpbtb_pkg::PC_STEP;
        s1_next   = s1_pred ? word_target : pc_next;
        s1_flush  = r_s1_op && ((r_s1_tk && (s1_next != r_s1_tgt)) ||
                                (!r_s1_tk && (s1_next != pc_next)));

        // Allocate on a miss, then train counter and history
        s1_alloc = !s1_hit;
        hist_upd = (s1_alloc && !r_cfg.global_history) ? '0 : hist_pred;
        base_row = (s1_alloc && !r_cfg.global_table) ? init_row : row_data;
        upd_slot = f_slot(r_s1_pc, hist_upd, hmask, r_cfg.share_mode);
        ctr_old  = base_row[{upd_slot, 1'b0} +: bpbtb_pkg::CTR_W];
        if (r_s1_tk) begin
            ctr_new = (ctr_old == bpbtb_pkg::CTR_MAX) ? ctr_old : ctr_old + 2'd1;
        end else begin
            ctr_new = (ctr_old == bpbtb_pkg::CTR_MIN) ? ctr_old : ctr_old - 2'd1;
        end
        new_row = base_row;
        new_row[{upd_slot, 1'b0} +: bpbtb_pkg::CTR_W] = ctr_new;
        new_hist = HIST_MAX'({hist_upd, r_s1_tk}) & hmask;
        new_btb  = {s1_tag, r_s1_tgt, new_hist};
        s1_write = s1_adv && r_s1_op;
    end

    // Valid bits, shared history and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            r_entry_valid <= '0;
            r_row_valid   <= '0;
            r_ghist       <= '0;
            r_branches    <= '0;
            r_flushes     <= '0;
        end else if (s1_write) begin
            r_entry_valid[r_s1_idx] <= 1'b1;
            r_row_valid[r_s1_row]   <= 1'b1;
            if (r_cfg.global_history) begin
                r_ghist <= new_hist;
            end
            r_branches <= r_branches + 32'd1;
            if (s1_flush) begin
                r_flushes <= r_flushes + 32'd1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_taken    <= s1_pred;
            r_out_target   <= s1_next;
            r_out_branches <= r_branches + {31'd0, r_s1_op};
            r_out_flushes  <= r_flushes + {31'd0, s1_flush};
        end
    end

    assign o_valid            = r_out_valid;
    assign o_predicted_taken  = r_out_taken;
    assign o_predicted_target = r_out_target;
    assign o_branch_count     = r_out_branches;
    assign o_flush_count      = r_out_flushes;

    // A predicted-taken result always comes from a hitting entry
    a_pred_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_pred) |-> s1_hit)
        else $error("taken prediction without a BTB hit");

    // Each update advances the branch count by exactly one
    a_branch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_op && !i_cfg_we) |=> (r_branches == $past(r_branches) + 32'd1))
        else $error("branch count did not step on an update");

    // Predict-only words leave entries and counts untouched
    a_predict_readonly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !r_s1_op && !i_cfg_we) |=>
            ($stable(r_entry_valid) && $stable(r_flushes) && $stable(r_branches)))
        else $error("predict-only word changed predictor state");

    // A word left in stage 1 by a stall keeps its bypass selection
    a_fwd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> ($stable(r_fwd_btb) && $stable(r_fwd_row)))
        else $error("bypass changed under a held word");

endmodule
